### hw/rtl/apvt_pkg.sv
`default_nettype none

package apvt_pkg;

    // Field widths of one stream item.
    localparam int DATA_WIDTH  = 32;
    localparam int CMD_WIDTH   = 2;
    localparam int IDX_WIDTH   = 4;

    // Fixed-point format and clamp range of the results.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Matrix shape: three rows of four columns, row-major.
    localparam int MAT_ROWS    = 3;
    localparam int MAT_COLS    = 4;
    localparam int NUM_COEFFS  = MAT_ROWS * MAT_COLS;
    localparam int NUM_AXES    = 3;

    // Arithmetic widths: full product, rounded product term, sum of four terms.
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int TERM_WIDTH  = PROD_WIDTH - FRAC_BITS;
    localparam int SUM_WIDTH   = TERM_WIDTH + 2;

    // Stream packing.
    localparam int IN_TDATA_WIDTH  = 136;
    localparam int OUT_TDATA_WIDTH = 96;

    // Command queue between front and back.
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_WIDTH  = $clog2(FIFO_DEPTH + 1);

    // The value 1.0 in the coefficient format.
    localparam logic [DATA_WIDTH-1:0] COEFF_ONE = DATA_WIDTH'(64'd1 << FRAC_BITS);

    // Bounds of the signed coordinate range, at the sum width.
    localparam logic signed [SUM_WIDTH-1:0] COORD_MAX =
        {{(SUM_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] COORD_MIN = ~COORD_MAX;

    typedef logic [CMD_WIDTH-1:0] cmd_t;

    localparam cmd_t CMD_LOAD   = 2'd0;
    localparam cmd_t CMD_POINT  = 2'd1;
    localparam cmd_t CMD_VECTOR = 2'd2;
    localparam cmd_t CMD_CONTRA = 2'd3;

    // One classified operation as it travels through the queue.
    // For a load, d0 carries the coefficient value.
    typedef struct packed {
        cmd_t                          cmd;
        logic [IDX_WIDTH-1:0]          index;
        logic signed [DATA_WIDTH-1:0]  d0;
        logic signed [DATA_WIDTH-1:0]  d1;
        logic signed [DATA_WIDTH-1:0]  d2;
    } op_t;

endpackage

`default_nettype wire

### hw/rtl/apvt_front.sv
`default_nettype none

module apvt_front (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // coeff_index, coeff_value, in_x, in_y, in_z, zero padding
    input  wire  [apvt_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
    // command
    input  wire  [apvt_pkg::CMD_WIDTH-1:0]        s_axis_tuser,
    output logic                                  push,
    output apvt_pkg::op_t                         push_op,
    input  wire                                   full
);

    localparam int IDX_LSB = 0;
    localparam int VAL_LSB = IDX_LSB + apvt_pkg::IDX_WIDTH;
    localparam int X_LSB   = VAL_LSB + apvt_pkg::DATA_WIDTH;
    localparam int Y_LSB   = X_LSB + apvt_pkg::DATA_WIDTH;
    localparam int Z_LSB   = Y_LSB + apvt_pkg::DATA_WIDTH;

    logic           valid_reg;
    logic           valid_next;
    apvt_pkg::op_t  op_reg;
    apvt_pkg::op_t  op_next;
    apvt_pkg::op_t  in_op;
    logic           accept;
    logic           keep;

    // Unpack the incoming transaction into an operation.
    always_comb
    begin
        in_op.cmd   = s_axis_tuser;
        in_op.index = s_axis_tdata[IDX_LSB +: apvt_pkg::IDX_WIDTH];
        if (s_axis_tuser == apvt_pkg::CMD_LOAD)
        begin
            in_op.d0 = s_axis_tdata[VAL_LSB +: apvt_pkg::DATA_WIDTH];
        end
        else
        begin
            in_op.d0 = s_axis_tdata[X_LSB +: apvt_pkg::DATA_WIDTH];
        end
        in_op.d1 = s_axis_tdata[Y_LSB +: apvt_pkg::DATA_WIDTH];
        in_op.d2 = s_axis_tdata[Z_LSB +: apvt_pkg::DATA_WIDTH];
    end

    // A load to an index past the matrix has no effect and is dropped here.
    assign keep = !((in_op.cmd == apvt_pkg::CMD_LOAD) &&
                    (in_op.index >= apvt_pkg::IDX_WIDTH'(apvt_pkg::NUM_COEFFS)));

    assign s_axis_tready = !valid_reg || !full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = valid_reg && !full;
    assign push_op       = op_reg;

    // The holding register refills whenever it is empty or its content moves into the queue.
    always_comb
    begin
        valid_next = valid_reg;
        op_next    = op_reg;
        if (s_axis_tready)
        begin
            valid_next = accept && keep;
            op_next    = in_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

endmodule

`default_nettype wire

### hw/rtl/apvt_fifo.sv
`default_nettype none

module apvt_fifo (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  apvt_pkg::op_t   push_op,
    output logic            full,
    input  wire             pop,
    output apvt_pkg::op_t   pop_op,
    output logic            empty
);

    apvt_pkg::op_t                          mem_reg [apvt_pkg::FIFO_DEPTH];
    logic [apvt_pkg::FIFO_PTR_WIDTH-1:0]    wr_ptr_reg;
    logic [apvt_pkg::FIFO_PTR_WIDTH-1:0]    wr_ptr_next;
    logic [apvt_pkg::FIFO_PTR_WIDTH-1:0]    rd_ptr_reg;
    logic [apvt_pkg::FIFO_PTR_WIDTH-1:0]    rd_ptr_next;
    logic [apvt_pkg::FIFO_CNT_WIDTH-1:0]    count_reg;
    logic [apvt_pkg::FIFO_CNT_WIDTH-1:0]    count_next;

    assign full   = (count_reg == apvt_pkg::FIFO_CNT_WIDTH'(apvt_pkg::FIFO_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    // The fill count stays within the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= apvt_pkg::FIFO_CNT_WIDTH'(apvt_pkg::FIFO_DEPTH))
        else $error("queue fill count beyond depth");

    // A push into a full queue or a pop from an empty one never happens.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overrun or underrun");

endmodule

`default_nettype wire

### hw/rtl/apvt_back.sv
`default_nettype none

module apvt_back (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   empty,
    input  apvt_pkg::op_t                         pop_op,
    output logic                                  pop,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // out_x, out_y, out_z
    output logic [apvt_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
    // saturated
    output logic [0:0]                            m_axis_tuser
);

    typedef logic signed [apvt_pkg::TERM_WIDTH-1:0] term_t;
    typedef logic signed [apvt_pkg::SUM_WIDTH-1:0]  sum_t;
    typedef logic signed [apvt_pkg::DATA_WIDTH-1:0] word_t;

    // Coefficient matrix, row-major.
    word_t  coeff_reg [apvt_pkg::NUM_COEFFS];

    // Multiply stage.
    logic   a_valid_reg;
    logic   a_valid_next;
    term_t  prod_reg  [apvt_pkg::MAT_ROWS][apvt_pkg::NUM_AXES];
    term_t  prod_next [apvt_pkg::MAT_ROWS][apvt_pkg::NUM_AXES];
    word_t  trans_reg [apvt_pkg::MAT_ROWS];
    word_t  trans_next[apvt_pkg::MAT_ROWS];

    // Output register.
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [apvt_pkg::OUT_TDATA_WIDTH-1:0]   out_data_reg;
    logic [apvt_pkg::OUT_TDATA_WIDTH-1:0]   out_data_next;
    logic                                   out_sat_reg;
    logic                                   out_sat_next;

    logic   a_ready;
    logic   b_ready;
    logic   issue_load;
    logic   issue_xform;
    word_t  coord [apvt_pkg::NUM_AXES];

    assign b_ready     = !out_valid_reg || m_axis_tready;
    assign a_ready     = !a_valid_reg || b_ready;
    assign issue_load  = !empty && (pop_op.cmd == apvt_pkg::CMD_LOAD);
    assign issue_xform = !empty && (pop_op.cmd != apvt_pkg::CMD_LOAD) && a_ready;
    assign pop         = issue_load || issue_xform;

    assign coord[0] = pop_op.d0;
    assign coord[1] = pop_op.d1;
    assign coord[2] = pop_op.d2;

    // Coefficient loads take effect in queue order, between transforms.
    // Reset gives 1.0 on the diagonal and zero elsewhere, translation included.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < apvt_pkg::MAT_ROWS; r++)
            begin
                for (int c = 0; c < apvt_pkg::MAT_COLS; c++)
                begin
                    if (r == c)
                    begin
                        coeff_reg[r * apvt_pkg::MAT_COLS + c] <= apvt_pkg::COEFF_ONE;
                    end
                    else
                    begin
                        coeff_reg[r * apvt_pkg::MAT_COLS + c] <= '0;
                    end
                end
            end
        end
        else if (issue_load)
        begin
            for (int i = 0; i < apvt_pkg::NUM_COEFFS; i++)
            begin
                if (pop_op.index == apvt_pkg::IDX_WIDTH'(i))
                begin
                    coeff_reg[i] <= pop_op.d0;
                end
            end
        end
    end

    // Nine parallel products, each rounded toward minus infinity.
    // Contravariant mode reads the 3x3 part transposed.
    always_comb
    begin
        logic signed [apvt_pkg::PROD_WIDTH-1:0] prod;
        word_t                                  sel;
        for (int r = 0; r < apvt_pkg::MAT_ROWS; r++)
        begin
            for (int c = 0; c < apvt_pkg::NUM_AXES; c++)
            begin
                if (pop_op.cmd == apvt_pkg::CMD_CONTRA)
                begin
                    sel = coeff_reg[c * apvt_pkg::MAT_COLS + r];
                end
                else
                begin
                    sel = coeff_reg[r * apvt_pkg::MAT_COLS + c];
                end
                prod = sel * coord[c];
                prod_next[r][c] = prod[apvt_pkg::PROD_WIDTH-1:apvt_pkg::FRAC_BITS];
            end
            if (pop_op.cmd == apvt_pkg::CMD_POINT)
            begin
                trans_next[r] = coeff_reg[r * apvt_pkg::MAT_COLS + apvt_pkg::MAT_COLS - 1];
            end
            else
            begin
                trans_next[r] = '0;
            end
        end
    end

    // Exact row sums, clamped to the coordinate range.
    always_comb
    begin
        sum_t sum;
        sum_t clamped;
        out_sat_next  = 1'b0;
        out_data_next = '0;
        for (int r = 0; r < apvt_pkg::MAT_ROWS; r++)
        begin
            sum = apvt_pkg::SUM_WIDTH'(prod_reg[r][0]) + apvt_pkg::SUM_WIDTH'(prod_reg[r][1])
                + apvt_pkg::SUM_WIDTH'(prod_reg[r][2]) + apvt_pkg::SUM_WIDTH'(trans_reg[r]);
            if (sum > apvt_pkg::COORD_MAX)
            begin
                clamped      = apvt_pkg::COORD_MAX;
                out_sat_next = 1'b1;
            end
            else if (sum < apvt_pkg::COORD_MIN)
            begin
                clamped      = apvt_pkg::COORD_MIN;
                out_sat_next = 1'b1;
            end
            else
            begin
                clamped = sum;
            end
            out_data_next[r * apvt_pkg::DATA_WIDTH +: apvt_pkg::DATA_WIDTH] =
                clamped[apvt_pkg::DATA_WIDTH-1:0];
        end
    end

    // Stage valid flags advance when the next stage has room.
    always_comb
    begin
        a_valid_next   = a_valid_reg;
        out_valid_next = out_valid_reg;
        if (a_ready)
        begin
            a_valid_next = issue_xform;
        end
        if (b_ready)
        begin
            out_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (issue_xform)
        begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
        end
        if (a_valid_reg && b_ready)
        begin
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_sat_reg;

    // A stalled product stage keeps its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_ready |=> a_valid_reg)
        else $error("product stage lost a stalled transaction");

    // A coefficient load never enters the product stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        issue_load |=> (a_valid_reg == $past(a_valid_reg && !b_ready)))
        else $error("load entered the product stage");

    // A saturated result has at least one coordinate at a range bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_sat_reg |->
            (out_data_reg[31:0]  == apvt_pkg::COORD_MAX[31:0]) ||
            (out_data_reg[31:0]  == apvt_pkg::COORD_MIN[31:0]) ||
            (out_data_reg[63:32] == apvt_pkg::COORD_MAX[31:0]) ||
            (out_data_reg[63:32] == apvt_pkg::COORD_MIN[31:0]) ||
            (out_data_reg[95:64] == apvt_pkg::COORD_MAX[31:0]) ||
            (out_data_reg[95:64] == apvt_pkg::COORD_MIN[31:0]))
        else $error("saturation flag without a clamped coordinate");

endmodule

`default_nettype wire

### hw/rtl/affine_point_vector_transform.sv
`default_nettype none

// Streaming 3D affine transform with a 3x4 matrix of Q16.16 coefficients that
// resets to identity. The command in tuser selects a coefficient load (no
// output transaction) or a point, vector or contravariant transform (one
// output transaction each). Transactions of any kind are taken one per clock
// cycle while the output is not back-pressured; a transform result passes
// through the input register, four-entry command queue, multiply stage and
// sum and clamp stage with output register before it is offered on the output.
// Loads pass through the same queue and apply in order, so a transform always
// sees every load that came before it. The rate is set by the nine parallel
// 32x32 multipliers, which take a new coordinate triple every cycle unless
// the output stage is stalled.

module affine_point_vector_transform (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // coeff_index, coeff_value, in_x, in_y, in_z, zero padding
    input  wire  [apvt_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
    // command
    input  wire  [apvt_pkg::CMD_WIDTH-1:0]        s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // out_x, out_y, out_z
    output logic [apvt_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
    // saturated
    output logic [0:0]                            m_axis_tuser
);

    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    apvt_pkg::op_t  push_op;
    apvt_pkg::op_t  pop_op;

    // Accept and classify incoming transactions.
    apvt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_op       (push_op),
        .full          (full)
    );

    // Command queue between the two sides.
    apvt_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .pop_op  (pop_op),
        .empty   (empty)
    );

    // Matrix storage, multiply and sum pipeline.
    apvt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .pop_op        (pop_op),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
